>>> rtl/slfl_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the sorted location to frame lookup.
package slfl_pkg;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int unsigned IndexW = 10;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] location_mm;
    logic [31:0] frame_number;
  } item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [31:0]       found_frame;
    logic [IndexW-1:0] found_index;
    logic              exact_hit;
  } result_t;

  typedef enum logic [2:0] {
    RES_DONE,
    RES_FULL,
    RES_EMPTY,
    RES_HIT,
    RES_MISS
  } res_sel_e;

  typedef struct packed {
    logic     init;
    logic     append;
    logic     clear;
    logic     step;
    logic     res_load;
    res_sel_e res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic hit;
    logic stop;
  } dp_sts_t;

endpackage

>>> rtl/slfl_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: command decode and bisection sequencing.
module slfl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [1:0]       command_i,
  input  slfl_pkg::dp_sts_t sts_i,
  output slfl_pkg::dp_cmd_t cmd_o,
  output logic             busy,
  output logic             done_o
);
  import slfl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FRAME
  } state_e;

  state_e  state_q, state_d;
  logic    done_q, done_d;
  dp_cmd_t cmd;

  always_comb begin
    cmd     = '0;
    cmd.res_sel = RES_DONE;
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd.res_load = 1'b1;
          done_d       = 1'b1;
          unique case (command_i)
            CMD_APPEND: begin
              if (sts_i.cnt_full) begin
                cmd.res_sel = RES_FULL;
              end else begin
                cmd.append = 1'b1;
              end
            end
            CMD_CLEAR: begin
              cmd.clear = 1'b1;
            end
            CMD_LOOKUP: begin
              if (sts_i.cnt_zero) begin
                cmd.res_sel = RES_EMPTY;
              end else begin
                cmd.init     = 1'b1;
                cmd.res_load = 1'b0;
                done_d       = 1'b0;
                state_d      = S_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (sts_i.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_HIT;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd.step = 1'b1;
          if (sts_i.stop) begin
            state_d = S_FRAME;
          end
        end
      end
      S_FRAME: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_MISS;
        done_d       = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign cmd_o  = cmd;
  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

>>> rtl/slfl_dp.sv
`timescale 1ns / 1ps
// Datapath: point tables, entry count, bisection bounds and result register.
module slfl_dp #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slfl_pkg::item_t   item_i,
  input  slfl_pkg::dp_cmd_t cmd_i,
  output slfl_pkg::dp_sts_t sts_o,
  output slfl_pkg::result_t result_o
);
  import slfl_pkg::*;

  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned ExtW  = (CntW > IndexW) ? CntW : IndexW;

  logic [31:0] loc_mem [TABLE_DEPTH];
  logic [31:0] frm_mem [TABLE_DEPTH];

  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  lower_q, upper_q, idx_q;
  logic [CntW-1:0]  lower_d, upper_d, idx_d;
  logic [31:0]      query_q;
  logic [31:0]      rd_loc_q, rd_frm_q;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [CntW:0]    bound_sum;
  logic             loc_gt;
  logic [ExtW-1:0]  idx_ext;
  result_t          result_q, result_d;

  assign loc_gt    = (rd_loc_q > query_q);
  assign upper_d   = loc_gt ? idx_q : upper_q;
  assign lower_d   = loc_gt ? lower_q : idx_q;
  assign bound_sum = {1'b0, upper_d} + {1'b0, lower_d};
  assign idx_d     = bound_sum[CntW:1];

  assign rd_addr = cmd_i.init ? AddrW'(count_q >> 1) : AddrW'(idx_d);
  assign wr_addr = AddrW'(count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      loc_mem[wr_addr] <= item_i.location_mm;
      frm_mem[wr_addr] <= item_i.frame_number;
    end
    rd_loc_q <= loc_mem[rd_addr];
    rd_frm_q <= frm_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
    end else if (cmd_i.append) begin
      count_q <= count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      query_q <= item_i.location_mm;
      lower_q <= '0;
      upper_q <= count_q;
      idx_q   <= count_q >> 1;
    end else if (cmd_i.step) begin
      lower_q <= lower_d;
      upper_q <= upper_d;
      idx_q   <= idx_d;
    end
  end

  assign idx_ext = ExtW'(idx_q);

  always_comb begin
    result_d = '0;
    unique case (cmd_i.res_sel)
      RES_DONE:  result_d.status = ST_DONE;
      RES_FULL:  result_d.status = ST_FULL;
      RES_EMPTY: result_d.status = ST_EMPTY;
      RES_HIT: begin
        result_d.status      = ST_DONE;
        result_d.found_frame = rd_frm_q;
        result_d.found_index = idx_ext[IndexW-1:0];
        result_d.exact_hit   = 1'b1;
      end
      RES_MISS: begin
        result_d.status      = ST_DONE;
        result_d.found_frame = rd_frm_q;
        result_d.found_index = idx_ext[IndexW-1:0];
      end
      default: result_d.status = ST_DONE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      result_q <= result_d;
    end
  end

  assign sts_o.cnt_zero = (count_q == '0);
  assign sts_o.cnt_full = (count_q == CntW'(TABLE_DEPTH));
  assign sts_o.hit      = (rd_loc_q == query_q);
  assign sts_o.stop     = (idx_d == upper_d) || (idx_d == lower_d);
  assign result_o       = result_q;

endmodule

>>> rtl/sorted_location_frame_lookup.sv
`timescale 1ns / 1ps
// Top level: sorted location to frame lookup table with bisection search.
// Append, clear and unused commands answer with done_o in the cycle after the
// beat is taken and never raise busy. A lookup on a table of N entries runs
// bisection steps, each step being one read of the location and frame tables
// on their single read port, then a frame state that loads the last frame read
// into the result register; an early exact match ends the search sooner. Each
// result is loaded into result_o with done_o high for exactly one cycle and
// cannot be held off; a new beat may be started in that same cycle. The tables
// need no clearing after reset.
module sorted_location_frame_lookup #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  slfl_pkg::item_t   item_i,
  output logic              busy,
  output logic              done_o,
  output slfl_pkg::result_t result_o
);
  import slfl_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  slfl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (item_i.command),
    .sts_i     (dp_sts),
    .cmd_o     (dp_cmd),
    .busy      (busy),
    .done_o    (done_o)
  );

  slfl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (dp_cmd),
    .sts_o    (dp_sts),
    .result_o (result_o)
  );

endmodule

>>> rtl/slfl_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the lookup block, bound to the top level.
module slfl_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input slfl_pkg::item_t   item_i,
  input logic              busy,
  input logic              done_o,
  input slfl_pkg::result_t result_o
);
  import slfl_pkg::*;

  a_short_cmd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.command != CMD_LOOKUP) |=> (done_o && !busy))
    else $error("non-lookup beat did not finish in one cycle");

  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || start))
    else $error("result beat without a pending item");

  a_busy_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("lookup ended without a result beat");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != ST_DONE) |->
      (!result_o.exact_hit && result_o.found_frame == '0 && result_o.found_index == '0))
    else $error("error result carries lookup fields");

endmodule

bind sorted_location_frame_lookup slfl_checker u_slfl_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .item_i   (item_i),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
